// ===== src/indent_to_brace_converter_unit_assert.svh =====
// assertion macros used by the sequencer of the indent to brace converter rtl
`ifndef INDENT_TO_BRACE_CONVERTER_UNIT_ASSERT_SVH
`define INDENT_TO_BRACE_CONVERTER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define ICB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define ICB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/icb_pkg.sv =====
// types, constants and defaults of the indent to brace converter
package icb_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int MAX_LEADING_DEF = 32;
  localparam int TAB_WIDTH_DEF   = 8;
  localparam int CMD_Q_DEPTH     = 2;

  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_EOS  = 1'b1;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_NEL    = 8'h85;
  localparam logic [7:0] CH_NBSP   = 8'hA0;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_MIXED     = 3'd1,
    ST_UNALIGNED = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_TOO_LONG  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CLS_TEXT    = 2'd0,
    CLS_BLANK   = 2'd1,
    CLS_NEWLINE = 2'd2,
    CLS_EOS     = 2'd3
  } cls_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] status;
    logic       stream_done;
    logic       last;
  } out_item_t;

  // classified request handed from front to back
  typedef struct packed {
    cls_e       cls;
    logic       is_tab;
    logic       is_ws;
    logic       is_bs;
    logic [7:0] byte_value;
  } cmd_t;

endpackage

// ===== src/icb_ram.sv =====
// generic single write port ram with registered read
module icb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/icb_front.sv =====
// input stage: takes requests and classifies each byte
module icb_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  icb_pkg::in_item_t in_item_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output icb_pkg::cmd_t     cmd_o
);
  import icb_pkg::*;

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  logic accept;
  logic [7:0] b;

  assign b      = in_item_i.byte_value;
  assign full_o = valid_q & ~cmd_ready_i;
  assign accept = push_i & ~full_o;

  always_comb begin
    cmd_d.byte_value = b;
    cmd_d.is_tab     = (b == CH_TAB);
    cmd_d.is_bs      = (b == CH_BSLASH);
    cmd_d.is_ws      = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_NL) ||
                       (b == CH_VT) || (b == CH_FF) || (b == CH_NEL) || (b == CH_NBSP);
    if (in_item_i.kind == KIND_EOS) begin
      cmd_d.cls = CLS_EOS;
    end else if (b == CH_NL) begin
      cmd_d.cls = CLS_NEWLINE;
    end else if ((b == CH_SPACE) || (b == CH_TAB)) begin
      cmd_d.cls = CLS_BLANK;
    end else begin
      cmd_d.cls = CLS_TEXT;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

// ===== src/icb_cmd_queue.sv =====
// short request queue between the classifier and the sequencer
module icb_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  icb_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output icb_pkg::cmd_t data_o,
  output logic          empty_o
);
  import icb_pkg::*;

  localparam int PtrW = $clog2(CMD_Q_DEPTH);
  localparam int CntW = $clog2(CMD_Q_DEPTH + 1);

  cmd_t            mem_q [CMD_Q_DEPTH];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(CMD_Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(CMD_Q_DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(CMD_Q_DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ===== src/icb_back.sv =====
// sequencer: indentation stack, line state and result generation
`include "indent_to_brace_converter_unit_assert.svh"

module icb_back #(
  parameter int STACK_DEPTH = icb_pkg::STACK_DEPTH_DEF,
  parameter int MAX_LEADING = icb_pkg::MAX_LEADING_DEF,
  parameter int TAB_WIDTH   = icb_pkg::TAB_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  icb_pkg::cmd_t      cmd_i,
  output logic              cmd_pop_o,
  output logic              out_valid_o,
  input  logic              pop_i,
  output icb_pkg::out_item_t out_item_o
);
  import icb_pkg::*;

  localparam int LcW  = $clog2(STACK_DEPTH + 1);
  localparam int IdxW = $clog2(STACK_DEPTH);
  localparam int BcW  = $clog2(MAX_LEADING + 1);
  localparam int ColW = $clog2(MAX_LEADING * TAB_WIDTH + 1);
  localparam int ModW = $clog2(TAB_WIDTH + 1);
  localparam int CntW = $clog2(MAX_LEADING + STACK_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CLOSE, S_OPEN_NL, S_PUSH, S_POP_WAIT, S_POP, S_BR_EXTRA,
    S_BR_REPL, S_BLANKS, S_BYTE, S_EOS_BR, S_ERR, S_FIN
  } state_e;

  typedef enum logic [1:0] {BK_NONE, BK_SPACE, BK_TAB} blank_kind_e;
  typedef enum logic [1:0] {REL_EQ, REL_UP, REL_DOWN} rel_e;

  state_e      state_q, state_d;
  cmd_t        cmd_q, cmd_d;
  logic [LcW-1:0]  lc_q, lc_d;
  logic [ColW-1:0] top_q, top_d, col_q, col_d;
  logic [BcW-1:0]  bc_q, bc_d;
  blank_kind_e bkind_q, bkind_d;
  logic [ModW-1:0] mod_q, mod_d;
  logic        in_content_q, in_content_d;
  logic        line_started_q, line_started_d;
  logic        nl_pending_q, nl_pending_d;
  logic        tail_seen_q, tail_seen_d;
  logic        tail_bs_q, tail_bs_d;
  logic        halted_q, halted_d;
  logic [CntW-1:0] cnt_q, cnt_d, rep_q, rep_d, repl;
  rel_e        rel_q, rel_d;
  status_e     err_q, err_d;
  out_item_t   hold_q, hold_d, out_q, out_d;
  logic        hold_valid_q, hold_valid_d, out_valid_q, out_valid_d;

  logic        out_free, gen_ok, gen, load_out, ram_we, pop_more;
  out_item_t   gen_item, load_item;
  logic [7:0]  blank_char;
  logic [ColW-1:0] ram_rdata, below;
  state_e      close_next, blanks_next;

  icb_ram #(
    .WIDTH(ColW),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(lc_q[IdxW-1:0]),
    .wdata_i(col_q),
    .raddr_i(IdxW'(lc_q - LcW'(2))),
    .rdata_o(ram_rdata)
  );

  assign out_free   = ~out_valid_q | pop_i;
  assign gen_ok     = ~hold_valid_q | out_free;
  assign blank_char = (bkind_q == BK_TAB) ? CH_TAB : CH_SPACE;
  // the bottom level is column 0 and never lives in the ram
  assign below      = (lc_q == LcW'(2)) ? '0 : ram_rdata;
  assign pop_more   = (lc_q > LcW'(1)) && (top_q > col_q);
  assign repl       = (cnt_q < CntW'(bc_q)) ? cnt_q : CntW'(bc_q);
  assign close_next = (cmd_q.cls == CLS_EOS) ? S_EOS_BR : S_FIN;

  always_comb begin
    case (cmd_q.cls)
      CLS_EOS:     blanks_next = S_EOS_BR;
      CLS_NEWLINE: blanks_next = S_FIN;
      default:     blanks_next = S_BYTE;
    endcase
  end

  always_comb begin
    state_d        = state_q;
    cmd_d          = cmd_q;
    lc_d           = lc_q;
    top_d          = top_q;
    col_d          = col_q;
    bc_d           = bc_q;
    bkind_d        = bkind_q;
    mod_d          = mod_q;
    in_content_d   = in_content_q;
    line_started_d = line_started_q;
    nl_pending_d   = nl_pending_q;
    tail_seen_d    = tail_seen_q;
    tail_bs_d      = tail_bs_q;
    halted_d       = halted_q;
    cnt_d          = cnt_q;
    rep_d          = rep_q;
    rel_d          = rel_q;
    err_d          = err_q;
    hold_d         = hold_q;
    hold_valid_d   = hold_valid_q;
    out_d          = out_q;
    out_valid_d    = out_valid_q;
    cmd_pop_o      = 1'b0;
    ram_we         = 1'b0;
    gen            = 1'b0;
    gen_item       = '0;
    gen_item.byte_valid = 1'b1;
    load_out       = 1'b0;
    load_item      = hold_q;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          if (halted_q) begin
            // dropped until reset
          end else if (cmd_i.cls == CLS_EOS) begin
            state_d = line_started_q ? S_CLOSE : S_EOS_BR;
          end else if (cmd_i.cls == CLS_NEWLINE) begin
            state_d = S_CLOSE;
          end else if ((cmd_i.cls == CLS_BLANK) && !in_content_q) begin
            if ((bkind_q != BK_NONE) && ((bkind_q == BK_TAB) != cmd_i.is_tab)) begin
              err_d   = ST_MIXED;
              state_d = S_ERR;
            end else if (bc_q >= BcW'(MAX_LEADING)) begin
              err_d   = ST_TOO_LONG;
              state_d = S_ERR;
            end else begin
              bc_d           = bc_q + BcW'(1);
              bkind_d        = cmd_i.is_tab ? BK_TAB : BK_SPACE;
              line_started_d = 1'b1;
              if (cmd_i.is_tab) begin
                col_d = col_q + ColW'(TAB_WIDTH) - ColW'(mod_q);
                mod_d = '0;
              end else begin
                col_d = col_q + ColW'(1);
                mod_d = (mod_q == ModW'(TAB_WIDTH - 1)) ? '0 : mod_q + ModW'(1);
              end
            end
          end else begin
            line_started_d = 1'b1;
            if (in_content_q) begin
              state_d = S_BYTE;
            end else if (col_q > top_q) begin
              if (lc_q >= LcW'(STACK_DEPTH)) begin
                err_d   = ST_OVERFLOW;
                state_d = S_ERR;
              end else begin
                rel_d        = REL_UP;
                in_content_d = 1'b1;
                state_d      = S_OPEN_NL;
              end
            end else begin
              rel_d        = (col_q < top_q) ? REL_DOWN : REL_EQ;
              in_content_d = 1'b1;
              state_d      = S_OPEN_NL;
            end
          end
        end
      end

      S_CLOSE: begin
        if (!in_content_q) begin
          if (nl_pending_q) begin
            if (gen_ok) begin
              gen               = 1'b1;
              gen_item.out_byte = CH_NL;
              nl_pending_d      = 1'b0;
            end
          end else begin
            cnt_d   = CntW'(bc_q);
            state_d = S_BLANKS;
          end
        end else if (tail_seen_q && !tail_bs_q) begin
          if (gen_ok) begin
            gen               = 1'b1;
            gen_item.out_byte = CH_SEMI;
            state_d           = close_next;
          end
        end else begin
          state_d = close_next;
        end
      end

      S_OPEN_NL: begin
        if (nl_pending_q) begin
          if (gen_ok) begin
            gen               = 1'b1;
            gen_item.out_byte = CH_NL;
            nl_pending_d      = 1'b0;
          end
        end else begin
          unique case (rel_q)
            REL_UP: state_d = S_PUSH;
            REL_DOWN: begin
              cnt_d   = '0;
              state_d = S_POP_WAIT;
            end
            default: begin
              cnt_d   = CntW'(bc_q);
              state_d = S_BLANKS;
            end
          endcase
        end
      end

      S_PUSH: begin
        if (gen_ok) begin
          ram_we            = 1'b1;
          lc_d              = lc_q + LcW'(1);
          top_d             = col_q;
          gen               = 1'b1;
          gen_item.out_byte = CH_LBRACE;
          // the brace takes the place of the first blank
          cnt_d             = CntW'(bc_q) - CntW'(1);
          tail_seen_d       = 1'b1;
          tail_bs_d         = 1'b0;
          state_d           = S_BLANKS;
        end
      end

      // lets the registered stack read catch up with the new level count
      S_POP_WAIT: state_d = S_POP;

      S_POP: begin
        if (pop_more) begin
          lc_d    = lc_q - LcW'(1);
          top_d   = below;
          cnt_d   = cnt_q + CntW'(1);
          state_d = S_POP_WAIT;
        end else begin
          rep_d   = repl;
          cnt_d   = cnt_q - repl;
          state_d = S_BR_EXTRA;
        end
      end

      // closing braces beyond the leading blanks go before the line
      S_BR_EXTRA: begin
        if (cnt_q == '0) begin
          if (top_q != col_q) begin
            err_d   = ST_UNALIGNED;
            state_d = S_ERR;
          end else begin
            cnt_d   = rep_q;
            state_d = S_BR_REPL;
          end
        end else if (gen_ok) begin
          gen               = 1'b1;
          gen_item.out_byte = CH_RBRACE;
          cnt_d             = cnt_q - CntW'(1);
        end
      end

      S_BR_REPL: begin
        if (cnt_q == '0) begin
          cnt_d   = CntW'(bc_q) - rep_q;
          state_d = S_BLANKS;
        end else if (gen_ok) begin
          gen               = 1'b1;
          gen_item.out_byte = CH_RBRACE;
          cnt_d             = cnt_q - CntW'(1);
        end
      end

      S_BLANKS: begin
        if (cnt_q == '0) begin
          state_d = blanks_next;
        end else if (gen_ok) begin
          gen               = 1'b1;
          gen_item.out_byte = blank_char;
          cnt_d             = cnt_q - CntW'(1);
        end
      end

      S_BYTE: begin
        if (gen_ok) begin
          gen               = 1'b1;
          gen_item.out_byte = cmd_q.byte_value;
          if (!cmd_q.is_ws) begin
            tail_seen_d = 1'b1;
            tail_bs_d   = cmd_q.is_bs;
          end
          state_d = S_FIN;
        end
      end

      S_EOS_BR: begin
        if (lc_q > LcW'(1)) begin
          if (gen_ok) begin
            gen               = 1'b1;
            gen_item.out_byte = CH_RBRACE;
            lc_d              = lc_q - LcW'(1);
          end
        end else if (!hold_valid_q) begin
          // nothing emitted for this end of stream: send an empty marker
          gen                 = 1'b1;
          gen_item.byte_valid = 1'b0;
          state_d             = S_FIN;
        end else begin
          state_d = S_FIN;
        end
      end

      S_ERR: begin
        if (gen_ok) begin
          gen                 = 1'b1;
          gen_item.byte_valid = 1'b0;
          gen_item.status     = err_q;
          halted_d            = 1'b1;
          state_d             = S_FIN;
        end
      end

      S_FIN: begin
        if (out_free || !hold_valid_q) begin
          if (hold_valid_q) begin
            load_out              = 1'b1;
            load_item.last        = 1'b1;
            load_item.stream_done = (cmd_q.cls == CLS_EOS);
            hold_valid_d          = 1'b0;
          end
          if ((cmd_q.cls == CLS_NEWLINE) || (cmd_q.cls == CLS_EOS)) begin
            bc_d           = '0;
            bkind_d        = BK_NONE;
            col_d          = '0;
            mod_d          = '0;
            in_content_d   = 1'b0;
            line_started_d = 1'b0;
            tail_seen_d    = 1'b0;
            tail_bs_d      = 1'b0;
            nl_pending_d   = (cmd_q.cls == CLS_NEWLINE);
          end
          if (cmd_q.cls == CLS_EOS) begin
            lc_d  = LcW'(1);
            top_d = '0;
          end
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // new result goes to the hold slot, the one before it moves on
    if (gen) begin
      if (hold_valid_q) begin
        load_out = 1'b1;
      end
      hold_d       = gen_item;
      hold_valid_d = 1'b1;
    end

    if (load_out) begin
      out_d       = load_item;
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      cmd_q          <= '0;
      lc_q           <= LcW'(1);
      top_q          <= '0;
      col_q          <= '0;
      bc_q           <= '0;
      bkind_q        <= BK_NONE;
      mod_q          <= '0;
      in_content_q   <= 1'b0;
      line_started_q <= 1'b0;
      nl_pending_q   <= 1'b0;
      tail_seen_q    <= 1'b0;
      tail_bs_q      <= 1'b0;
      halted_q       <= 1'b0;
      cnt_q          <= '0;
      rep_q          <= '0;
      rel_q          <= REL_EQ;
      err_q          <= ST_OK;
      hold_q         <= '0;
      hold_valid_q   <= 1'b0;
      out_q          <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      cmd_q          <= cmd_d;
      lc_q           <= lc_d;
      top_q          <= top_d;
      col_q          <= col_d;
      bc_q           <= bc_d;
      bkind_q        <= bkind_d;
      mod_q          <= mod_d;
      in_content_q   <= in_content_d;
      line_started_q <= line_started_d;
      nl_pending_q   <= nl_pending_d;
      tail_seen_q    <= tail_seen_d;
      tail_bs_q      <= tail_bs_d;
      halted_q       <= halted_d;
      cnt_q          <= cnt_d;
      rep_q          <= rep_d;
      rel_q          <= rel_d;
      err_q          <= err_d;
      hold_q         <= hold_d;
      hold_valid_q   <= hold_valid_d;
      out_q          <= out_d;
      out_valid_q    <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `ICB_ASSERT_NEXT(a_halt_sticky, halted_q, halted_q, "halted flag cleared without reset")
  `ICB_ASSERT_NOW(a_push_room, ram_we, lc_q < LcW'(STACK_DEPTH), "push beyond stack depth")
  `ICB_ASSERT_NOW(a_out_no_overwrite, load_out, !out_valid_q || pop_i, "output overwritten")
  `ICB_ASSERT_NEXT(a_eos_unwinds, (state_q == S_FIN) && (cmd_q.cls == CLS_EOS) && gen_ok, lc_q == LcW'(1), "levels left open after end of stream")

endmodule

// ===== src/indent_to_brace_converter_unit.sv =====
// top level: classifier front, request queue and sequencer back
// a line byte passes the front register, a queue entry, the sequencer request register, the hold slot and
// the output register; a content byte runs through the idle, byte and fin states, a leading blank only
// through idle, and a line start adds states for its newline, braces and blanks and a stack ram read wait
// per closed level; reset is asynchronous and active low; it empties all queues and leaves one open level
// at column 0, no clearing pass is needed since stack entries are written before being read
module indent_to_brace_converter_unit #(
  parameter int STACK_DEPTH = icb_pkg::STACK_DEPTH_DEF,
  parameter int MAX_LEADING = icb_pkg::MAX_LEADING_DEF,
  parameter int TAB_WIDTH   = icb_pkg::TAB_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  icb_pkg::in_item_t  in_item_i,
  output logic              empty,
  input  logic              pop,
  output icb_pkg::out_item_t out_item_o
);
  import icb_pkg::*;

  logic front_valid, q_full, q_empty, back_pop, out_valid;
  cmd_t front_cmd, q_cmd;

  icb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .in_item_i  (in_item_i),
    .cmd_valid_o(front_valid),
    .cmd_ready_i(~q_full),
    .cmd_o      (front_cmd)
  );

  icb_cmd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_valid),
    .data_i (front_cmd),
    .full_o (q_full),
    .pop_i  (back_pop),
    .data_o (q_cmd),
    .empty_o(q_empty)
  );

  icb_back #(
    .STACK_DEPTH(STACK_DEPTH),
    .MAX_LEADING(MAX_LEADING),
    .TAB_WIDTH  (TAB_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(~q_empty),
    .cmd_i      (q_cmd),
    .cmd_pop_o  (back_pop),
    .out_valid_o(out_valid),
    .pop_i      (pop),
    .out_item_o (out_item_o)
  );

  assign empty = ~out_valid;

endmodule
